/* rtl/longest_prefix_match_table_core_macros.svh */
// Assertion macros shared by the routing table RTL.
`ifndef LONGEST_PREFIX_MATCH_TABLE_CORE_MACROS_SVH
`define LONGEST_PREFIX_MATCH_TABLE_CORE_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
// The enclosing module must provide clk and rst_n.
`define LPM_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define LPM_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* rtl/lpm_pkg.sv */
// Shared constants, types and a helper function for the routing table.
`default_nettype none
package lpm_pkg;

    localparam int ROUTE_SLOTS = 64;
    localparam int METRIC_BITS = 16;
    localparam int SLOT_BITS   = $clog2(ROUTE_SLOTS);
    localparam int COUNT_BITS  = $clog2(ROUTE_SLOTS + 1);

    localparam logic [5:0] LEN_MAX = 6'd32;

    localparam logic [1:0] STATUS_HIT  = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_ADD,
        OP_REMOVE,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [31:0]            addr;
        logic [5:0]             len;
        logic [31:0]            hop;
        logic [METRIC_BITS-1:0] metric;
    } cmd_t;

    typedef struct packed {
        logic [31:0]            prefix;
        logic [5:0]             len;
        logic [31:0]            hop;
        logic [METRIC_BITS-1:0] metric;
    } slot_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] hop;
        logic [5:0]  matched_len;
        logic [15:0] best_metric;
        logic [6:0]  route_count;
        logic        table_empty;
    } res_t;

    // Network mask for a prefix length that is already limited to 32.
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] mask;
        if (len == 6'd0)
        begin
            mask = 32'h0;
        end
        else if (len >= LEN_MAX)
        begin
            mask = 32'hFFFF_FFFF;
        end
        else
        begin
            mask = 32'hFFFF_FFFF << (LEN_MAX - len);
        end
        return mask;
    endfunction

endpackage
`default_nettype wire

/* rtl/lpm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/lpm_front.sv */
// Front end: takes items, decodes the operation and holds them in a two-entry queue.
`default_nettype none
module lpm_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [1:0]   mode,
    input  wire logic [31:0]  address,
    input  wire logic [5:0]   prefix_len,
    input  wire logic [31:0]  next_hop,
    input  wire logic [15:0]  metric,
    output lpm_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  wire logic         cmd_take
);
    import lpm_pkg::*;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    cmd_t        dec;
    logic [31:0] metric_wide;
    logic        do_push;
    logic        do_pop;

    // Classify the item and bring its fields into stored form.
    always_comb
    begin
        metric_wide = 32'(metric);
        case (mode)
            MODE_LOOKUP: dec.op = OP_LOOKUP;
            MODE_ADD:    dec.op = OP_ADD;
            MODE_REMOVE: dec.op = OP_REMOVE;
            default:     dec.op = OP_NONE;
        endcase
        dec.addr   = address;
        dec.len    = (prefix_len > LEN_MAX) ? LEN_MAX : prefix_len;
        dec.hop    = next_hop;
        dec.metric = metric_wide[METRIC_BITS-1:0];
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule
`default_nettype wire

/* rtl/lpm_back.sv */
// Back end: scans the slot memory for each command, updates the table and queues results.
`default_nettype none
module lpm_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire lpm_pkg::cmd_t cmd,
    input  wire logic         cmd_valid,
    output logic              cmd_take,
    output lpm_pkg::res_t     res,
    output logic              res_empty,
    input  wire logic         res_pop
);
    import lpm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(ROUTE_SLOTS - 1);

    state_t                 state_reg;
    cmd_t                   cur_reg;
    logic [SLOT_BITS-1:0]   scan_idx_reg;
    logic                   eval_vld_reg;
    logic [SLOT_BITS-1:0]   eval_idx_reg;
    logic [ROUTE_SLOTS-1:0] valid_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;

    logic                   best_found_reg;
    logic [5:0]             best_len_reg;
    logic [METRIC_BITS-1:0] best_met_reg;
    logic [31:0]            best_hop_reg;
    logic                   exact_found_reg;
    logic [SLOT_BITS-1:0]   exact_idx_reg;
    logic                   free_found_reg;
    logic [SLOT_BITS-1:0]   free_idx_reg;

    res_t                   oq_reg [2];
    logic                   oq_wr_reg;
    logic                   oq_rd_reg;
    logic [1:0]             oq_cnt_reg;

    logic [$bits(slot_t)-1:0] ram_rdata;
    slot_t                  rd_slot;
    slot_t                  wr_slot;
    logic                   ram_we;
    logic [SLOT_BITS-1:0]   ram_waddr;

    logic                   ent_valid;
    logic                   ent_free;
    logic [31:0]            mask;
    logic                   ent_hit;
    logic                   ent_better;
    logic                   ent_exact;

    logic                   add_ok;
    logic [SLOT_BITS-1:0]   add_idx;
    res_t                   res_new;
    logic [31:0]            count_wide;
    logic [31:0]            met_wide;
    logic                   do_push;
    logic                   do_pop;

    lpm_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (ROUTE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_slot),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_slot  = slot_t'(ram_rdata);
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid && (oq_cnt_reg != 2'd2);

    // Per-slot evaluation of the entry that the memory returned this cycle.
    always_comb
    begin
        ent_valid  = eval_vld_reg && valid_reg[eval_idx_reg];
        ent_free   = eval_vld_reg && !valid_reg[eval_idx_reg];
        mask       = len_mask(rd_slot.len);
        ent_hit    = ent_valid && ((cur_reg.addr & mask) == (rd_slot.prefix & mask));
        ent_better = ent_hit && (!best_found_reg || (rd_slot.len > best_len_reg) ||
                     ((rd_slot.len == best_len_reg) && (rd_slot.metric < best_met_reg)));
        ent_exact  = ent_valid && (rd_slot.prefix == cur_reg.addr) &&
                     (rd_slot.len == cur_reg.len);
    end

    // Table update and result for the command when the scan is complete.
    always_comb
    begin
        add_ok     = exact_found_reg || free_found_reg;
        add_idx    = exact_found_reg ? exact_idx_reg : free_idx_reg;
        ram_we     = (state_reg == S_FINISH) && (cur_reg.op == OP_ADD) && add_ok;
        ram_waddr  = add_idx;
        wr_slot.prefix = cur_reg.addr;
        wr_slot.len    = cur_reg.len;
        wr_slot.hop    = cur_reg.hop;
        wr_slot.metric = cur_reg.metric;

        count_next = count_reg;
        res_new.status      = STATUS_MISS;
        res_new.hop         = 32'h0;
        res_new.matched_len = 6'd0;
        res_new.best_metric = 16'h0;
        met_wide            = 32'(best_met_reg);

        case (cur_reg.op)
            OP_LOOKUP:
            begin
                if (best_found_reg)
                begin
                    res_new.status      = STATUS_HIT;
                    res_new.hop         = best_hop_reg;
                    res_new.matched_len = best_len_reg;
                    res_new.best_metric = met_wide[15:0];
                end
            end
            OP_ADD:
            begin
                if (add_ok)
                begin
                    res_new.status = STATUS_HIT;
                    if (!exact_found_reg)
                    begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                end
                else
                begin
                    res_new.status = STATUS_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (exact_found_reg)
                begin
                    res_new.status = STATUS_HIT;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - COUNT_BITS'(1);
                    end
                end
            end
            default:
            begin
                res_new.status = STATUS_MISS;
            end
        endcase

        count_wide          = 32'(count_next);
        res_new.route_count = count_wide[6:0];
        res_new.table_empty = (count_next == '0);
    end

    assign do_push   = (state_reg == S_FINISH);
    assign do_pop    = res_pop && (oq_cnt_reg != 2'd0);
    assign res_empty = (oq_cnt_reg == 2'd0);
    assign res       = oq_reg[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            scan_idx_reg    <= '0;
            eval_vld_reg    <= 1'b0;
            valid_reg       <= '0;
            count_reg       <= '0;
            best_found_reg  <= 1'b0;
            exact_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            oq_wr_reg       <= 1'b0;
            oq_rd_reg       <= 1'b0;
            oq_cnt_reg      <= 2'd0;
        end
        else
        begin
            eval_vld_reg <= (state_reg == S_SCAN);

            if (ent_better)
            begin
                best_found_reg <= 1'b1;
            end
            if (ent_exact && !exact_found_reg)
            begin
                exact_found_reg <= 1'b1;
            end
            if (ent_free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        scan_idx_reg    <= '0;
                        best_found_reg  <= 1'b0;
                        exact_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        state_reg       <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + SLOT_BITS'(1);
                    if (scan_idx_reg == LAST_SLOT)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    count_reg <= count_next;
                    if (cur_reg.op == OP_ADD && add_ok)
                    begin
                        valid_reg[add_idx] <= 1'b1;
                    end
                    if (cur_reg.op == OP_REMOVE && exact_found_reg)
                    begin
                        valid_reg[exact_idx_reg] <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (do_push)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (do_pop)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            if (do_push && !do_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + 2'd1;
            end
            else if (!do_push && do_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg - 2'd1;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        eval_idx_reg <= scan_idx_reg;
        if (cmd_take)
        begin
            cur_reg <= cmd;
        end
        if (ent_better)
        begin
            best_len_reg <= rd_slot.len;
            best_met_reg <= rd_slot.metric;
            best_hop_reg <= rd_slot.hop;
        end
        if (ent_exact && !exact_found_reg)
        begin
            exact_idx_reg <= eval_idx_reg;
        end
        if (ent_free && !free_found_reg)
        begin
            free_idx_reg <= eval_idx_reg;
        end
        if (do_push)
        begin
            oq_reg[oq_wr_reg] <= res_new;
        end
    end

endmodule
`default_nettype wire

/* rtl/longest_prefix_match_table_core.sv */
// Top level of the IPv4 longest-prefix-match routing table.
// The back end walks all ROUTE_SLOTS slots for each command (one slot memory read per cycle).
// It takes no new command until the last one is finished and its result queued, as the slot
// memory has a single read port; a full result queue also holds new commands back.
// Reset clears all slot valid bits and the route count at once; no clearing pass is needed.
`default_nettype none
`include "longest_prefix_match_table_core_macros.svh"
module longest_prefix_match_table_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] address,
    input  wire logic [5:0]  prefix_len,
    input  wire logic [31:0] next_hop,
    input  wire logic [15:0] metric,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       status,
    output logic [31:0]      hop,
    output logic [5:0]       matched_len,
    output logic [15:0]      best_metric,
    output logic [6:0]       route_count,
    output logic             table_empty
);
    import lpm_pkg::*;

    // The front end decodes each transfer into a command and buffers up to two of them,
    // so the source can keep pushing while the back end is busy scanning the table.
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;
    res_t res;

    lpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .address    (address),
        .prefix_len (prefix_len),
        .next_hop   (next_hop),
        .metric     (metric),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take)
    );

    // The back end walks every slot once per command. Lookups track the longest match with
    // the lowest metric; adds and removes track the first exact match and the first free
    // slot. The table is updated and the result queued once the walk is finished. Its
    // two-entry result queue lets a finished result wait while the next command runs.
    lpm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop)
    );

    assign status      = res.status;
    assign hop         = res.hop;
    assign matched_len = res.matched_len;
    assign best_metric = res.best_metric;
    assign route_count = res.route_count;
    assign table_empty = res.table_empty;

    // The route count can never pass the number of slots.
    `LPM_ASSERT_SAME(a_count_bound, !empty, route_count <= 7'(ROUTE_SLOTS), "route count too large")

    // The empty flag agrees with the count it travels with.
    `LPM_ASSERT_SAME(a_empty_flag, !empty, table_empty == (route_count == 7'd0), "empty flag wrong")

    // A full report only comes when every slot is in use.
    `LPM_ASSERT_SAME(a_full_count, !empty && status == STATUS_FULL,
        route_count == 7'(ROUTE_SLOTS), "table full reported with free slots")

    // Only a lookup hit carries route data.
    `LPM_ASSERT_SAME(a_miss_zero, !empty && status != STATUS_HIT,
        hop == 32'h0 && matched_len == 6'd0 && best_metric == 16'h0, "route data on miss")

endmodule
`default_nettype wire
